// ===== rtl/core/hcbd_pkg.sv =====
`default_nettype none

package hcbd_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam int HEX_BASE_ALPHA = 10;
    localparam int OUT_TDATA_W    = 16;

    typedef enum logic [3:0] {
        PH_WS         = 4'd0,
        PH_SIGN       = 4'd1,
        PH_ZERO       = 4'd2,
        PH_DIGITS     = 4'd3,
        PH_REST       = 4'd4,
        PH_DATA       = 4'd5,
        PH_AFTER_DATA = 4'd6,
        PH_AFTER_CR   = 4'd7,
        PH_DONE       = 4'd8
    } phase_t;

    typedef enum logic [3:0] {
        CLS_LF    = 4'd0,
        CLS_CR    = 4'd1,
        CLS_WS    = 4'd2,
        CLS_PLUS  = 4'd3,
        CLS_MINUS = 4'd4,
        CLS_ZERO  = 4'd5,
        CLS_HEX   = 4'd6,
        CLS_X     = 4'd7,
        CLS_OTHER = 4'd8
    } cls_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LINE  = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        cls_t       cls;
        logic [3:0] hexv;
    } q_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/hcbd_front.sv =====
`default_nettype none

module hcbd_front
    import hcbd_pkg::*;
(
    input  wire logic [7:0] data,
    input  wire logic       last,
    output q_entry_t        entry
);

    cls_t       cls;
    logic [3:0] hexv;

    always_comb
    begin
        cls  = CLS_OTHER;
        hexv = 4'd0;
        if (data == CH_LF)
        begin
            cls = CLS_LF;
        end
        else if (data == CH_CR)
        begin
            cls = CLS_CR;
        end
        else if (data == CH_SPACE || data == CH_HT || data == CH_VT || data == CH_FF)
        begin
            cls = CLS_WS;
        end
        else if (data == CH_PLUS)
        begin
            cls = CLS_PLUS;
        end
        else if (data == CH_MINUS)
        begin
            cls = CLS_MINUS;
        end
        else if (data == CH_ZERO)
        begin
            cls = CLS_ZERO;
        end
        else if (data > CH_ZERO && data <= CH_NINE)
        begin
            cls  = CLS_HEX;
            hexv = 4'(data - CH_ZERO);
        end
        else if (data >= CH_LA && data <= CH_LF_HEX)
        begin
            cls  = CLS_HEX;
            hexv = 4'(data - CH_LA + 8'(HEX_BASE_ALPHA));
        end
        else if (data >= CH_UA && data <= CH_UF)
        begin
            cls  = CLS_HEX;
            hexv = 4'(data - CH_UA + 8'(HEX_BASE_ALPHA));
        end
        else if (data == CH_LX || data == CH_UX)
        begin
            cls = CLS_X;
        end
    end

    assign entry.data = data;
    assign entry.last = last;
    assign entry.cls  = cls;
    assign entry.hexv = hexv;

endmodule

`default_nettype wire

// ===== rtl/core/hcbd_fifo.sv =====
`default_nettype none

module hcbd_fifo
    import hcbd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    output logic          full,
    input  wire logic     pop,
    output logic          not_empty,
    output q_entry_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hcbd_back.sv =====
`default_nettype none

module hcbd_back
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 31
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       entry_valid,
    input  wire q_entry_t   entry,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_byte,
    output logic            m_byte_valid,
    output logic            m_end,
    output logic [1:0]      m_status,
    output phase_t          phase
);

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [SIZE_BITS-1:0]   acc_reg;
    logic [SIZE_BITS-1:0]   acc_next;
    logic [SIZE_BITS-1:0]   left_reg;
    logic [SIZE_BITS-1:0]   left_next;
    logic                   dig_reg;
    logic                   dig_next;
    logic                   bad_reg;
    logic                   bad_next;
    logic [1:0]             err_reg;
    logic [1:0]             err_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_byte_reg;
    logic [7:0]             out_byte_next;
    logic                   out_bv_reg;
    logic                   out_bv_next;
    logic                   out_end_reg;
    logic                   out_end_next;
    logic [1:0]             out_status_reg;
    logic [1:0]             out_status_next;

    logic                   data_byte;
    logic                   fresh;
    logic                   run_line;
    phase_t                 lp;
    logic [SIZE_BITS-1:0]   la;
    logic                   ld;
    logic                   lb;
    logic                   is_hex;
    logic                   ovf;
    logic [1:0]             status;

    assign pop    = entry_valid && (!out_valid_reg || m_ready);
    assign is_hex = (entry.cls == CLS_HEX) || (entry.cls == CLS_ZERO);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        dig_next   = dig_reg;
        bad_next   = bad_reg;
        err_next   = err_reg;
        data_byte  = 1'b0;
        fresh      = 1'b0;
        run_line   = 1'b0;
        status     = ST_OK;

        unique case (phase_reg)
            PH_DONE:
            begin
            end
            PH_DATA:
            begin
                data_byte = 1'b1;
                left_next = left_reg - 1'b1;
                if (left_reg == SIZE_BITS'(1))
                begin
                    phase_next = PH_AFTER_DATA;
                end
            end
            PH_AFTER_DATA:
            begin
                if (entry.cls == CLS_CR)
                begin
                    phase_next = PH_AFTER_CR;
                end
                else
                begin
                    fresh    = 1'b1;
                    run_line = (entry.cls != CLS_LF);
                end
            end
            PH_AFTER_CR:
            begin
                fresh    = 1'b1;
                run_line = (entry.cls != CLS_LF);
            end
            default:
            begin
                run_line = 1'b1;
            end
        endcase

        lp  = fresh ? PH_WS : phase_reg;
        la  = fresh ? '0 : acc_reg;
        ld  = fresh ? 1'b0 : dig_reg;
        lb  = fresh ? 1'b0 : bad_reg;
        ovf = (la[SIZE_BITS-1 -: 4] != 4'd0);

        if (fresh)
        begin
            phase_next = PH_WS;
            acc_next   = '0;
            dig_next   = 1'b0;
            bad_next   = 1'b0;
        end

        if (run_line)
        begin
            if (entry.cls == CLS_LF)
            begin
                if (lb || !ld)
                begin
                    err_next   = ST_BAD_LINE;
                    phase_next = PH_DONE;
                end
                else if (la == '0)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    left_next  = la;
                    phase_next = PH_DATA;
                end
            end
            else
            begin
                // sign/prefix handling folds the WS and SIGN phases together
                if ((lp == PH_WS && (entry.cls == CLS_WS || entry.cls == CLS_CR)))
                begin
                end
                else if (lp == PH_WS && entry.cls == CLS_PLUS)
                begin
                    phase_next = PH_SIGN;
                end
                else if (lp == PH_WS && entry.cls == CLS_MINUS)
                begin
                    bad_next   = 1'b1;
                    phase_next = PH_REST;
                end
                else if ((lp == PH_WS || lp == PH_SIGN) && entry.cls == CLS_ZERO)
                begin
                    dig_next   = 1'b1;
                    phase_next = PH_ZERO;
                end
                else if (lp == PH_ZERO && entry.cls == CLS_X)
                begin
                    phase_next = PH_DIGITS;
                end
                else if ((lp == PH_WS || lp == PH_SIGN || lp == PH_ZERO || lp == PH_DIGITS)
                         && is_hex)
                begin
                    dig_next = 1'b1;
                    if (ovf)
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_REST;
                    end
                    else
                    begin
                        acc_next   = {la[SIZE_BITS-5:0], entry.hexv};
                        phase_next = PH_DIGITS;
                    end
                end
                else if (lp == PH_WS || lp == PH_SIGN || lp == PH_ZERO || lp == PH_DIGITS)
                begin
                    phase_next = PH_REST;
                end
            end
        end

        if (entry.last)
        begin
            status = err_next;
            if (phase_next == PH_DATA && err_next == ST_OK)
            begin
                status = ST_TRUNCATED;
            end
            phase_next = PH_WS;
            acc_next   = '0;
            left_next  = '0;
            dig_next   = 1'b0;
            bad_next   = 1'b0;
            err_next   = ST_OK;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_ready;
        out_byte_next   = out_byte_reg;
        out_bv_next     = out_bv_reg;
        out_end_next    = out_end_reg;
        out_status_next = out_status_reg;
        if (pop)
        begin
            out_valid_next  = data_byte || entry.last;
            out_byte_next   = data_byte ? entry.data : 8'd0;
            out_bv_next     = data_byte;
            out_end_next    = entry.last;
            out_status_next = entry.last ? status : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WS;
            acc_reg       <= '0;
            left_reg      <= '0;
            dig_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                left_reg  <= left_next;
                dig_reg   <= dig_next;
                bad_reg   <= bad_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_bv_reg     <= out_bv_next;
        out_end_reg    <= out_end_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_byte       = out_byte_reg;
    assign m_byte_valid = out_bv_reg;
    assign m_end        = out_end_reg;
    assign m_status     = out_status_reg;
    assign phase        = phase_reg;

endmodule

`default_nettype wire

// ===== rtl/core/http_chunked_body_decoder.sv =====
`default_nettype none

// channel  dir  tdata                                   tuser        tlast
// s_axis   in   [7:0] in_byte                           -            in_last
// m_axis   out  [7:0] out_byte, [9:8] out_status, pad   out_byte_valid  out_end
//
// One word per cycle in and at most one out while m_axis does not stall; a result
// is written into the queue, then into the output register, and then shows on m_axis.
// The classifier feeds a two-word queue; the decode FSM pops one word a cycle unless m_axis stalls.
// s_axis_tready drops only while the queue is full, i.e. when m_axis stalls.
// Reset is asynchronous; after the last word of a body the decoder starts fresh.

module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 31
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] in_byte
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [7:0] out_byte, [9:8] out_status
    output logic                        m_axis_tuser,   // [0] out_byte_valid
    output logic                        m_axis_tlast
);

    q_entry_t   front_entry;
    q_entry_t   head;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;
    logic [7:0] out_byte;
    logic [1:0] out_status;
    phase_t     back_phase;

    hcbd_front u_front
    (
        .data  (s_axis_tdata),
        .last  (s_axis_tlast),
        .entry (front_entry)
    );

    hcbd_fifo #(.DEPTH(2)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_axis_tvalid),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    hcbd_back #(.SIZE_BITS(SIZE_BITS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (q_not_empty),
        .entry        (head),
        .pop          (q_pop),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_byte       (out_byte),
        .m_byte_valid (m_axis_tuser),
        .m_end        (m_axis_tlast),
        .m_status     (out_status),
        .phase        (back_phase)
    );

    assign s_axis_tready = !q_full;
    assign m_axis_tdata  = {(OUT_TDATA_W - 10)'(0), out_status, out_byte};

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_axis_tready)
        else $error("input taken while queue full");

    a_mid_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser && out_status == ST_OK))
        else $error("non-final word without data or with status");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && head.last) |=> (back_phase == PH_WS))
        else $error("decoder not restarted after last word");

endmodule

`default_nettype wire
